@@ src/rc4sc_pkg.sv @@
// Package with the request and result types, register map and controller states of the RC4 block.
`timescale 1ns / 1ps

package rc4sc_pkg;

	localparam int unsigned APB_ADDR_W = 6;
	localparam int unsigned APB_DATA_W = 64;
	localparam int unsigned KEY_WORDS  = 4;
	localparam int unsigned KEY_BYTES  = 32;
	localparam int unsigned LEN_W      = 6;

	localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
	localparam logic [2:0] REG_KEY_WORD_0 = 3'd1;
	localparam logic [2:0] REG_KEY_WORD_1 = 3'd2;
	localparam logic [2:0] REG_KEY_WORD_2 = 3'd3;
	localparam logic [2:0] REG_KEY_WORD_3 = 3'd4;

	localparam logic OP_REKEY  = 1'b0;
	localparam logic OP_CIPHER = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       rekey_done;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_D_RDJ,
		ST_D_SWP,
		ST_D_WRJ,
		ST_K_FILL,
		ST_K_RDJ,
		ST_K_WRK,
		ST_K_WRJ,
		ST_K_DONE
	} state_t;

endpackage

@@ src/rc4_stream_cipher.sv @@
// RC4 stream cipher: key registers, permutation memory and the schedule and generator controller.
// The block takes requests on the cmd channel (cmd_valid, cmd_stall, cmd) and returns one
// result per request on the res channel (res_valid, res_stall, res). A request with operation
// zero runs the key schedule from the key held in the configuration registers; a request with
// operation one ciphers one data byte, which serves for encryption and decryption alike.
// The permutation lives in a 256 x 8 memory with one write port and one registered read port.
// A data request steps the controller through ST_D_RDJ, ST_D_SWP and ST_D_WRJ: one read of S[i],
// one read of S[j], and a swap whose first write overlaps the read of the keystream entry and
// whose second write goes with the registering of the result; only then is a new request taken.
// A rekey request first fills the memory with the identity, then runs 256 swap steps (states
// ST_K_RDJ, ST_K_WRK, ST_K_WRJ) on the single write port, and registers its result in ST_K_DONE.
// A data request must follow a rekey; before that the permutation holds no defined values.
// Reset clears the indices, the controller and the output valid flag, and sets the key length
// to one with an all-zero key; the memory itself is not cleared.
// The result waits in an output register while the receiver stalls; a new request is still
// accepted meanwhile, and the controller only waits when it has a second result to hand over.
// Configuration writes through the APB port are taken at any time but are meant for idle
// periods only.
`timescale 1ns / 1ps

module rc4_stream_cipher (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rc4sc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [rc4sc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [rc4sc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  rc4sc_pkg::cmd_t                      cmd,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output rc4sc_pkg::res_t                      res
);
	import rc4sc_pkg::*;

	logic [LEN_W-1:0]      key_length_q;
	logic [63:0]           key_q [KEY_WORDS];
	logic [2:0]            reg_idx;
	logic                  cfg_wr;

	logic [7:0]            mem [256];
	logic [7:0]            mem_rd_q;
	logic                  mem_we;
	logic [7:0]            mem_wa;
	logic [7:0]            mem_wd;
	logic                  mem_re;
	logic [7:0]            mem_ra;

	state_t                state_q;
	state_t                state_nxt;
	logic [7:0]            i_q;
	logic [7:0]            j_q;
	logic [7:0]            cnt_q;
	logic [4:0]            kpos_q;
	logic [4:0]            len_m1;
	logic [7:0]            held_q;
	logic [7:0]            data_q;
	logic                  hitj_q;
	logic                  res_valid_q;
	res_t                  res_q;

	logic                  cmd_acc;
	logic                  out_free;
	logic [7:0]            key_byte;
	logic [7:0]            j_sum;
	logic [7:0]            t_idx;
	logic [7:0]            ks_byte;
	logic                  res_ld;
	res_t                  res_nxt;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= LEN_W'(1);
			for (int w = 0; w < KEY_WORDS; w++) begin
				key_q[w] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_KEY_LENGTH: key_length_q <= pwdata[LEN_W-1:0];
				REG_KEY_WORD_0: key_q[0] <= pwdata;
				REG_KEY_WORD_1: key_q[1] <= pwdata;
				REG_KEY_WORD_2: key_q[2] <= pwdata;
				REG_KEY_WORD_3: key_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KEY_LENGTH: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, key_length_q};
			REG_KEY_WORD_0: prdata = key_q[0];
			REG_KEY_WORD_1: prdata = key_q[1];
			REG_KEY_WORD_2: prdata = key_q[2];
			REG_KEY_WORD_3: prdata = key_q[3];
			default:        prdata = '0;
		endcase
	end

	// Last key position used; a length of zero counts as one, lengths above the key as full.
	always_comb begin
		priority if (key_length_q == '0) begin
			len_m1 = '0;
		end else if (key_length_q > LEN_W'(KEY_BYTES)) begin
			len_m1 = 5'(KEY_BYTES - 1);
		end else begin
			len_m1 = 5'(key_length_q - LEN_W'(1));
		end
	end

	assign key_byte = key_q[kpos_q[4:3]][{kpos_q[2:0], 3'b000} +: 8];

	// Permutation memory; a read of the entry being written returns the new value.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= (mem_we && (mem_wa == mem_ra)) ? mem_wd : mem[mem_ra];
		end
	end

	// Handshake.
	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					state_nxt = (cmd.operation == OP_CIPHER) ? ST_D_RDJ : ST_K_FILL;
				end
			end
			ST_D_RDJ: state_nxt = ST_D_SWP;
			ST_D_SWP: state_nxt = ST_D_WRJ;
			ST_D_WRJ: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_K_FILL: begin
				if (cnt_q == 8'hFF) begin
					state_nxt = ST_K_RDJ;
				end
			end
			ST_K_RDJ: state_nxt = ST_K_WRK;
			ST_K_WRK: state_nxt = ST_K_WRJ;
			ST_K_WRJ: state_nxt = (cnt_q == 8'hFF) ? ST_K_DONE : ST_K_RDJ;
			ST_K_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Memory controls and result.
	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = '0;
		mem_wd  = '0;
		mem_re  = 1'b0;
		mem_ra  = '0;
		j_sum   = '0;
		t_idx   = '0;
		ks_byte = hitj_q ? held_q : mem_rd_q;
		res_ld  = 1'b0;
		res_nxt = '0;
		unique case (state_q)
			ST_IDLE: begin
				mem_re = cmd_acc && (cmd.operation == OP_CIPHER);
				mem_ra = i_q + 8'd1;
			end
			ST_D_RDJ: begin
				j_sum  = j_q + mem_rd_q;
				mem_re = 1'b1;
				mem_ra = j_sum;
			end
			ST_D_SWP: begin
				mem_we = 1'b1;
				mem_wa = i_q;
				mem_wd = mem_rd_q;
				t_idx  = held_q + mem_rd_q;
				mem_re = 1'b1;
				mem_ra = t_idx;
			end
			ST_D_WRJ: begin
				mem_we             = 1'b1;
				mem_wa             = j_q;
				mem_wd             = held_q;
				res_ld             = out_free;
				res_nxt.out_byte   = data_q ^ ks_byte;
				res_nxt.rekey_done = 1'b0;
			end
			ST_K_FILL: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = cnt_q;
				mem_re = 1'b1;
				mem_ra = cnt_q + 8'd1;
			end
			ST_K_RDJ: begin
				j_sum  = j_q + mem_rd_q + key_byte;
				mem_re = 1'b1;
				mem_ra = j_sum;
			end
			ST_K_WRK: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = mem_rd_q;
			end
			ST_K_WRJ: begin
				mem_we = 1'b1;
				mem_wa = j_q;
				mem_wd = held_q;
				mem_re = 1'b1;
				mem_ra = cnt_q + 8'd1;
			end
			ST_K_DONE: begin
				res_ld             = out_free;
				res_nxt.out_byte   = '0;
				res_nxt.rekey_done = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			cnt_q       <= '0;
			kpos_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (res_ld) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						if (cmd.operation == OP_CIPHER) begin
							i_q <= i_q + 8'd1;
						end else begin
							j_q    <= '0;
							cnt_q  <= '0;
							kpos_q <= '0;
						end
					end
				end
				ST_D_RDJ: j_q <= j_sum;
				ST_K_FILL: cnt_q <= cnt_q + 8'd1;
				ST_K_RDJ: j_q <= j_sum;
				ST_K_WRJ: begin
					cnt_q  <= cnt_q + 8'd1;
					kpos_q <= (kpos_q == len_m1) ? 5'd0 : kpos_q + 5'd1;
				end
				ST_K_DONE: begin
					if (out_free) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			data_q <= cmd.data_byte;
		end
		if ((state_q == ST_D_RDJ) || (state_q == ST_K_RDJ)) begin
			held_q <= mem_rd_q;
		end
		if (state_q == ST_D_SWP) begin
			hitj_q <= (t_idx == j_q);
		end
		if (res_ld) begin
			res_q <= res_nxt;
		end
	end

`ifndef SYNTHESIS
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("permutation memory written while idle");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> (state_q != ST_IDLE))
		else $error("accepted request did not start the controller");

	a_schedule_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_K_DONE) |-> (cnt_q == 8'd0))
		else $error("key schedule finished before all 256 swap steps");

	a_rekey_clears_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ld && res_nxt.rekey_done) |=> ((i_q == 8'd0) && (j_q == 8'd0)))
		else $error("indices not cleared after key schedule");
`endif

endmodule

@@ dv/testbench.sv @@
// Testbench for the RC4 stream cipher: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module testbench;
	import rc4sc_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT    = 20000;
	localparam int unsigned HOLD_OFF_CYCLES   = 400;
	localparam int unsigned END_SETTLE_CYCLES = 60;
	localparam int unsigned RANDOM_ITEMS      = 850;
	localparam logic [2:0]  REG_UNMAPPED_LO   = 3'd5;
	localparam logic [2:0]  REG_UNMAPPED_HI   = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  psel      = 1'b0;
	logic                  penable   = 1'b0;
	logic                  pwrite    = 1'b0;
	logic [APB_ADDR_W-1:0] paddr     = '0;
	logic [APB_DATA_W-1:0] pwdata    = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	cmd_t                  cmd       = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_t                  res;

	rc4_stream_cipher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: permutation, generator indices and the key registers.
	logic [7:0]       perm_state [256];
	logic [7:0]       gen_i;
	logic [7:0]       gen_j;
	logic [LEN_W-1:0] key_len_reg;
	logic [63:0]      key_word_reg [KEY_WORDS];

	res_t        expected_results [$];
	res_t        expected_head;
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles    = 0;
	int unsigned stall_left     = 0;
	int unsigned hold_left      = 0;
	bit          hold_off_go    = 1'b0;
	bit          calm           = 1'b0;

	function automatic void write_key_register(input logic [2:0] idx, input logic [63:0] value);
		case (idx)
			REG_KEY_LENGTH: key_len_reg = value[LEN_W-1:0];
			REG_KEY_WORD_0: key_word_reg[0] = value;
			REG_KEY_WORD_1: key_word_reg[1] = value;
			REG_KEY_WORD_2: key_word_reg[2] = value;
			REG_KEY_WORD_3: key_word_reg[3] = value;
			default: ;
		endcase
	endfunction

	function automatic void schedule_key();
		int unsigned len;
		logic [7:0]  acc;
		logic [7:0]  kb;
		logic [7:0]  tmp;
		int unsigned pos;
		len = key_len_reg;
		if (len == 0)
			len = 1;
		if (len > KEY_BYTES)
			len = KEY_BYTES;
		for (int k = 0; k < 256; k++)
			perm_state[k] = 8'(k);
		acc = 8'd0;
		for (int k = 0; k < 256; k++) begin
			pos = k % len;
			kb = key_word_reg[pos / 8][(pos % 8) * 8 +: 8];
			acc = acc + perm_state[k] + kb;
			tmp = perm_state[k];
			perm_state[k] = perm_state[acc];
			perm_state[acc] = tmp;
		end
		gen_i = 8'd0;
		gen_j = 8'd0;
	endfunction

	function automatic logic [7:0] keystream_byte();
		logic [7:0] tmp;
		gen_i = gen_i + 8'd1;
		gen_j = gen_j + perm_state[gen_i];
		tmp = perm_state[gen_i];
		perm_state[gen_i] = perm_state[gen_j];
		perm_state[gen_j] = tmp;
		return perm_state[8'(perm_state[gen_i] + perm_state[gen_j])];
	endfunction

	function automatic res_t predict_result(input cmd_t c);
		res_t r;
		if (c.operation == OP_REKEY) begin
			schedule_key();
			r.out_byte = 8'd0;
			r.rekey_done = 1'b1;
		end else begin
			r.out_byte = c.data_byte ^ keystream_byte();
			r.rekey_done = 1'b0;
		end
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		write_key_register(idx, value);
	endtask

	task automatic send_request(input logic op, input logic [7:0] data);
		int unsigned gap;
		cmd_t c;
		c.operation = op;
		c.data_byte = data;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (cmd_stall !== 1'b0);
		expected_results = {expected_results, predict_result(c)};
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_key();
		send_request(OP_REKEY, 8'hFF);
		send_request(OP_CIPHER, 8'h00);
		send_request(OP_CIPHER, 8'hFF);
		send_request(OP_CIPHER, 8'h55);
		send_request(OP_CIPHER, 8'hAA);
		drain();
	endtask

	task automatic test_key_lengths();
		logic [LEN_W-1:0] lengths [5];
		lengths = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63};
		apb_write(REG_KEY_WORD_0, '1);
		apb_write(REG_KEY_WORD_1, {$urandom, $urandom});
		apb_write(REG_KEY_WORD_2, {$urandom, $urandom});
		apb_write(REG_KEY_WORD_3, '1);
		foreach (lengths[n]) begin
			apb_write(REG_KEY_LENGTH, 64'(lengths[n]));
			send_request(OP_REKEY, 8'h00);
			send_request(OP_CIPHER, 8'($urandom));
			drain();
		end
	endtask

	task automatic test_unmapped_registers();
		for (logic [3:0] idx = {1'b0, REG_UNMAPPED_LO}; idx <= {1'b0, REG_UNMAPPED_HI}; idx++)
			apb_write(idx[2:0], {$urandom, $urandom});
		send_request(OP_REKEY, 8'($urandom));
		send_request(OP_CIPHER, 8'($urandom));
		drain();
	endtask

	task automatic test_rekey_mid_stream();
		send_request(OP_CIPHER, 8'($urandom));
		send_request(OP_REKEY, 8'($urandom));
		send_request(OP_REKEY, 8'($urandom));
		send_request(OP_CIPHER, 8'($urandom));
		drain();
	endtask

	task automatic test_output_backpressure();
		calm = 1'b1;
		hold_off_go = 1'b1;
		repeat (24)
			send_request(OP_CIPHER, 8'($urandom));
		drain();
		calm = 1'b0;
	endtask

	task automatic test_random_streams();
		int unsigned sent;
		int unsigned burst;
		int unsigned roll;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) != 0) begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					apb_write(REG_KEY_LENGTH, 64'd0);
				else if (roll == 1)
					apb_write(REG_KEY_LENGTH, 64'($urandom_range(33, 63)));
				else
					apb_write(REG_KEY_LENGTH, 64'($urandom_range(1, 32)));
				for (int w = 0; w < KEY_WORDS; w++)
					apb_write(3'(REG_KEY_WORD_0 + w), {$urandom, $urandom});
			end
			send_request(OP_REKEY, 8'($urandom));
			sent++;
			burst = $urandom_range(20, 80);
			repeat (burst) begin
				if ($urandom_range(0, 49) == 0)
					send_request(OP_REKEY, 8'($urandom));
				else
					send_request(OP_CIPHER, 8'($urandom));
				sent++;
			end
			drain();
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_off_go) begin
			hold_off_go = 1'b0;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
			if ($urandom_range(0, 2) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %h with no request pending", res));
			end else begin
				expected_head = expected_results.pop_front();
				if (res.out_byte !== expected_head.out_byte)
					report_mismatch($sformatf("out_byte %h, expected %h",
						res.out_byte, expected_head.out_byte));
				if (res.rekey_done !== expected_head.rekey_done)
					report_mismatch($sformatf("rekey_done %b, expected %b",
						res.rekey_done, expected_head.rekey_done));
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_stall === 1'b0) || (res_valid === 1'b1 && !res_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("rc4_stream_cipher regression: fail");
			$finish;
		end
	end

	initial begin
		perm_state = '{default: 8'd0};
		gen_i = 8'd0;
		gen_j = 8'd0;
		key_len_reg = 6'd1;
		key_word_reg = '{default: 64'd0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_key();
		test_key_lengths();
		test_unmapped_registers();
		test_rekey_mid_stream();
		test_output_backpressure();
		test_random_streams();
		drain();
		repeat (END_SETTLE_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (mismatch_count == 0)
			$display("rc4_stream_cipher regression: pass");
		else
			$display("rc4_stream_cipher regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
src/rc4sc_pkg.sv
src/rc4_stream_cipher.sv
dv/testbench.sv
